// ===== hw/rtl/qlt_pkg.sv =====
// types, codes and character constants shared by the tokenizer modules
package qlt_pkg;

    localparam int MAX_RES = 4;

    // result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_ESCAPE = 2'd1;
    localparam logic [1:0] ERR_LONE   = 2'd2;
    localparam logic [1:0] ERR_UNTERM = 2'd3;

    // configuration register indexes
    localparam logic [7:0] CFG_SPLIT_CHAR = 8'd0;
    localparam logic [7:0] CFG_UPPERCASE  = 8'd1;

    // reset values of the configuration registers
    localparam logic [7:0] SPLIT_CHAR_RST = 8'h20;
    localparam logic       UPPERCASE_RST  = 1'b1;

    // characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_last;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_char;
        logic [1:0] error_code;
        logic       run_last;
    } t_out;

    // one result without its run_last flag
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [1:0] err;
    } t_res;

    // all results of one item, queued between front and back
    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [1:0]         last_idx;
    } t_cmd;

    typedef struct packed {
        logic [7:0] split_char;
        logic       uppercase_enable;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic escape_ok(input logic [7:0] c);
        return c == CH_BSLASH || c == CH_QUOTE || c == CH_ZERO || c == CH_LC_A ||
               c == CH_LC_B || c == CH_LC_T || c == CH_LC_N || c == CH_LC_V ||
               c == CH_LC_F || c == CH_LC_R || c == CH_LC_E;
    endfunction

    function automatic t_res mk_res(input logic [1:0] kind, input logic [7:0] ch,
                                    input logic [1:0] err);
        t_res r;
        r.kind = kind;
        r.ch   = ch;
        r.err  = err;
        return r;
    endfunction

endpackage

// ===== hw/rtl/quoted_line_tokenizer.sv =====
// top level of the quoted line tokenizer: config registers, front, queue, back
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in  (ch, line_last)
//  out     | output    | o_out_valid / i_out_ready  | o_out (kind, out_char, error_code,
//          |           |                            |        run_last)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// the front takes one item per cycle while the result queue has room
// the back sends one result per cycle while the output is not stalled; an item has
//   one to four results, and items with no result are never queued
// an item's first result goes through a queue slot, then the output register
// reset clears the line state and the queue and loads split char 32, uppercase on
// a stalled output keeps the back waiting; the front keeps going until the queue fills
module quoted_line_tokenizer import qlt_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_q_stat q_stat;
    t_cmd    push_cmd, head_cmd;
    logic    push, pop;

    // config writes are always taken; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.split_char       <= SPLIT_CHAR_RST;
            r_cfg.uppercase_enable <= UPPERCASE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPLIT_CHAR: r_cfg.split_char       <= i_cfg_data;
                CFG_UPPERCASE:  r_cfg.uppercase_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // front: per-line state and classification into a bundle of results
    qlt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // queue decouples classification from the output side
    qlt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    // back: unrolls each bundle onto the output channel
    qlt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_cmd),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // never push into a full queue or pop an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("push into full result queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_stat.empty))
        else $error("pop from empty result queue");

    // line done is always the final result of its item
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.kind == KIND_DONE) |-> o_out.run_last)
        else $error("line done without run_last");

    // error code present exactly on error results
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.kind == KIND_ERROR) == (o_out.error_code != ERR_NONE)))
        else $error("error code does not match kind");

endmodule

// ===== hw/rtl/qlt_front.sv =====
// front end: line state, character classification, result bundle per item
module qlt_front import qlt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in     i_in,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_cmd    o_cmd
);

    logic r_in_string, r_esc, r_tok, r_skip;
    logic n_in_string, n_esc, n_tok, n_skip;
    logic [2:0] n_cnt;
    t_res [MAX_RES-1:0] n_res;
    logic accept;
    logic [7:0] c;

    assign o_in_ready = !i_q_stat.full;
    assign accept     = i_in_valid && o_in_ready;
    assign c          = i_in.ch;

    always_comb begin
        n_in_string = r_in_string;
        n_esc       = r_esc;
        n_tok       = r_tok;
        n_skip      = r_skip;
        n_cnt       = 3'd0;
        n_res       = '0;
        if (!r_skip) begin
            if (r_esc) begin
                n_esc = 1'b0;
                if (escape_ok(c)) begin
                    n_res[0] = mk_res(KIND_CHAR, CH_BSLASH, ERR_NONE);
                    n_res[1] = mk_res(KIND_CHAR, c, ERR_NONE);
                    n_cnt    = 3'd2;
                    n_tok    = 1'b1;
                end else begin
                    n_res[0] = mk_res(KIND_ERROR, 8'd0, ERR_ESCAPE);
                    n_cnt    = 3'd1;
                    n_skip   = 1'b1;
                end
            end else if (c == i_cfg.split_char) begin
                if (r_in_string) begin
                    n_res[0] = mk_res(KIND_CHAR, c, ERR_NONE);
                    n_cnt    = 3'd1;
                    n_tok    = 1'b1;
                end else if (r_tok) begin
                    n_res[0] = mk_res(KIND_END, 8'd0, ERR_NONE);
                    n_cnt    = 3'd1;
                    n_tok    = 1'b0;
                end
            end else if (c == CH_QUOTE) begin
                n_in_string = !r_in_string;
                n_res[0]    = mk_res(KIND_CHAR, c, ERR_NONE);
                n_cnt       = 3'd1;
                n_tok       = 1'b1;
            end else if (c == CH_BSLASH && r_in_string) begin
                if (i_in.line_last) begin
                    n_res[0] = mk_res(KIND_ERROR, 8'd0, ERR_LONE);
                    n_cnt    = 3'd1;
                    n_skip   = 1'b1;
                end else begin
                    n_esc = 1'b1;
                end
            end else if (c == CH_HASH) begin
                if (r_in_string) begin
                    n_res[0] = mk_res(KIND_CHAR, c, ERR_NONE);
                    n_cnt    = 3'd1;
                    n_tok    = 1'b1;
                end else begin
                    if (r_tok) begin
                        n_res[0] = mk_res(KIND_END, 8'd0, ERR_NONE);
                        n_cnt    = 3'd1;
                    end
                    n_tok  = 1'b0;
                    n_skip = 1'b1;
                end
            end else begin
                if (i_cfg.uppercase_enable && !r_in_string && c >= CH_LC_A && c <= CH_LC_Z)
                    n_res[0] = mk_res(KIND_CHAR, c - CASE_DIFF, ERR_NONE);
                else
                    n_res[0] = mk_res(KIND_CHAR, c, ERR_NONE);
                n_cnt = 3'd1;
                n_tok = 1'b1;
            end
        end

        if (i_in.line_last) begin
            if (!n_skip) begin
                if (n_in_string) begin
                    n_res[n_cnt[1:0]] = mk_res(KIND_ERROR, 8'd0, ERR_UNTERM);
                    n_cnt             = n_cnt + 3'd1;
                end else if (n_tok) begin
                    n_res[n_cnt[1:0]] = mk_res(KIND_END, 8'd0, ERR_NONE);
                    n_cnt             = n_cnt + 3'd1;
                end
            end
            n_res[n_cnt[1:0]] = mk_res(KIND_DONE, 8'd0, ERR_NONE);
            n_cnt             = n_cnt + 3'd1;
            n_in_string       = 1'b0;
            n_esc             = 1'b0;
            n_tok             = 1'b0;
            n_skip            = 1'b0;
        end
    end

    assign o_push       = accept && (n_cnt != 3'd0);
    assign o_cmd.res      = n_res;
    assign o_cmd.last_idx = 2'(n_cnt - 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string <= 1'b0;
            r_esc       <= 1'b0;
            r_tok       <= 1'b0;
            r_skip      <= 1'b0;
        end else if (accept) begin
            r_in_string <= n_in_string;
            r_esc       <= n_esc;
            r_tok       <= n_tok;
            r_skip      <= n_skip;
        end
    end

endmodule

// ===== hw/rtl/qlt_queue.sv =====
// small queue of result bundles between front and back
module qlt_queue import qlt_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
            if (i_pop)
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
            if (i_push && !i_pop)
                r_cnt <= r_cnt + CW'(1);
            else if (i_pop && !i_push)
                r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

// ===== hw/rtl/qlt_back.sv =====
// back end: walks a bundle one result per cycle into the output register while the output is not stalled
module qlt_back import qlt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_head,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out       r_out;
    logic       load, last_slot;
    t_res       slot;

    assign slot      = i_head.res[r_idx];
    assign last_slot = (r_idx == i_head.last_idx);
    assign load      = !i_q_stat.empty && (!r_out_valid || i_out_ready);
    assign o_pop     = load && last_slot;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.kind       <= slot.kind;
            r_out.out_char   <= slot.ch;
            r_out.error_code <= slot.err;
            r_out.run_last   <= last_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load)
                r_idx <= last_slot ? 2'd0 : r_idx + 2'd1;
            if (load)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== tb/qlt_checker.sv =====
// result checker for the quoted line tokenizer: mirrors the line state and compares results
`timescale 1ns / 1ps

module qlt_checker import qlt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in        i_in,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out       i_out,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    // mirrored registers and line state
    logic [7:0] split_sym;
    logic       upcase_en;
    logic       in_quotes;
    logic       escape_wait;
    logic       token_live;
    logic       discard_line;

    t_out awaited_results[$];
    int   fails;

    function automatic t_out result_of(input logic [1:0] kind, input logic [7:0] c,
                                       input logic [1:0] err);
        t_out r;
        r.kind       = kind;
        r.out_char   = c;
        r.error_code = err;
        r.run_last   = 1'b0;
        return r;
    endfunction

    function automatic logic legal_escape(input logic [7:0] c);
        case (c)
            CH_BSLASH, CH_QUOTE, CH_ZERO, CH_LC_A, CH_LC_B, CH_LC_T,
            CH_LC_N, CH_LC_V, CH_LC_F, CH_LC_R, CH_LC_E: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // work out the results of one character and queue them
    task automatic tokenize_char(input t_in item);
        t_out       res [MAX_RES];
        t_out       r;
        int         n;
        logic [7:0] c;
        n = 0;
        c = item.ch;
        if (discard_line) begin
            // rest of line dropped
        end else if (escape_wait) begin
            escape_wait = 1'b0;
            if (legal_escape(c)) begin
                res[n] = result_of(KIND_CHAR, CH_BSLASH, ERR_NONE);
                n = n + 1;
                res[n] = result_of(KIND_CHAR, c, ERR_NONE);
                n = n + 1;
                token_live = 1'b1;
            end else begin
                res[n] = result_of(KIND_ERROR, 8'h00, ERR_ESCAPE);
                n = n + 1;
                discard_line = 1'b1;
            end
        end else if (c == split_sym) begin
            if (in_quotes) begin
                res[n] = result_of(KIND_CHAR, c, ERR_NONE);
                n = n + 1;
                token_live = 1'b1;
            end else if (token_live) begin
                res[n] = result_of(KIND_END, 8'h00, ERR_NONE);
                n = n + 1;
                token_live = 1'b0;
            end
        end else if (c == CH_QUOTE) begin
            in_quotes = !in_quotes;
            res[n] = result_of(KIND_CHAR, c, ERR_NONE);
            n = n + 1;
            token_live = 1'b1;
        end else if (c == CH_BSLASH && in_quotes) begin
            if (item.line_last) begin
                res[n] = result_of(KIND_ERROR, 8'h00, ERR_LONE);
                n = n + 1;
                discard_line = 1'b1;
            end else begin
                escape_wait = 1'b1;
            end
        end else if (c == CH_HASH && in_quotes) begin
            res[n] = result_of(KIND_CHAR, c, ERR_NONE);
            n = n + 1;
            token_live = 1'b1;
        end else if (c == CH_HASH) begin
            if (token_live) begin
                res[n] = result_of(KIND_END, 8'h00, ERR_NONE);
                n = n + 1;
            end
            token_live   = 1'b0;
            discard_line = 1'b1;
        end else begin
            if (upcase_en && !in_quotes && c >= CH_LC_A && c <= CH_LC_Z)
                c = c - CASE_DIFF;
            res[n] = result_of(KIND_CHAR, c, ERR_NONE);
            n = n + 1;
            token_live = 1'b1;
        end

        if (item.line_last) begin
            if (!discard_line && in_quotes) begin
                res[n] = result_of(KIND_ERROR, 8'h00, ERR_UNTERM);
                n = n + 1;
            end else if (!discard_line && token_live) begin
                res[n] = result_of(KIND_END, 8'h00, ERR_NONE);
                n = n + 1;
            end
            res[n] = result_of(KIND_DONE, 8'h00, ERR_NONE);
            n = n + 1;
            in_quotes    = 1'b0;
            escape_wait  = 1'b0;
            token_live   = 1'b0;
            discard_line = 1'b0;
        end

        for (int i = 0; i < n; i++) begin
            r          = res[i];
            r.run_last = (i == n - 1);
            awaited_results = {awaited_results, r};
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            split_sym    = SPLIT_CHAR_RST;
            upcase_en    = UPPERCASE_RST;
            in_quotes    = 1'b0;
            escape_wait  = 1'b0;
            token_live   = 1'b0;
            discard_line = 1'b0;
            fails        = 0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with none awaited: kind %0d char %02h code %0d",
                           i_out.kind, i_out.out_char, i_out.error_code);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, i_out.kind);
                        fails++;
                    end
                    if (i_out.out_char !== want.out_char) begin
                        $error("out_char: expected %02h, got %02h",
                               want.out_char, i_out.out_char);
                        fails++;
                    end
                    if (i_out.error_code !== want.error_code) begin
                        $error("error_code: expected %0d, got %0d",
                               want.error_code, i_out.error_code);
                        fails++;
                    end
                    if (i_out.run_last !== want.run_last) begin
                        $error("run_last: expected %0d, got %0d",
                               want.run_last, i_out.run_last);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPLIT_CHAR: split_sym = i_cfg_data;
                    CFG_UPPERCASE:  upcase_en = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                tokenize_char(i_in);
        end
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
    end

endmodule

// ===== tb/quoted_line_tokenizer_tb.sv =====
// testbench top for the quoted line tokenizer: line stimulus, output stalls and verdict
`timescale 1ns / 1ps

module quoted_line_tokenizer_tb import qlt_pkg::*;;

    // settling wait after the last awaited result, for items that cause no result
    localparam int SETTLE_CYCLES = 8;
    // long output hold-off, well past what the result queue can absorb
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 14;
    localparam int NUM_PHASES    = 7;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in        in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out       out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;
    int         fail_count;
    int         pending;

    // idle percentages of sender and receiver
    int send_idle  = 31;
    int recv_idle  = 70;
    // long hold-off request and its countdown, owned by the receiver process
    int hold_kick  = 0;
    int hold_taken = 0;
    int hold_left  = 0;

    int         items_sent = 0;
    logic [7:0] line_buf[$];

    quoted_line_tokenizer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    qlt_checker tok_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_kick != hold_taken) begin
            hold_taken <= hold_kick;
            hold_left  <= LONG_HOLD;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // one of the eleven characters allowed after a backslash in a string
    function automatic logic [7:0] esc_char();
        case ($urandom_range(10))
            0:       return CH_BSLASH;
            1:       return CH_QUOTE;
            2:       return CH_ZERO;
            3:       return CH_LC_A;
            4:       return CH_LC_B;
            5:       return CH_LC_T;
            6:       return CH_LC_N;
            7:       return CH_LC_V;
            8:       return CH_LC_F;
            9:       return CH_LC_R;
            default: return CH_LC_E;
        endcase
    endfunction

    // mostly letters, so the uppercase path gets its share
    function automatic logic [7:0] word_char();
        case ($urandom_range(3))
            0, 1:    return 8'($urandom_range(CH_LC_A, CH_LC_Z));
            2:       return 8'($urandom_range(8'h21, 8'h7E));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // biased toward characters with a meaning of their own
    function automatic logic [7:0] noise_char(input logic [7:0] sep);
        case ($urandom_range(7))
            0:       return sep;
            1:       return CH_QUOTE;
            2:       return CH_BSLASH;
            3:       return CH_HASH;
            4:       return esc_char();
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {c, last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // send the buffered line, flagging its final character
    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1);
        items_sent += line_buf.size();
        line_buf.delete();
    endtask

    // append one character to the line under construction
    task automatic add_char(input logic [7:0] c);
        line_buf = {line_buf, c};
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    // random line: mostly words, quoted strings and comments joined by the
    // separator, with broken strings mixed in; some lines are pure noise
    task automatic build_line(input logic [7:0] sep);
        int parts;
        line_buf.delete();
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 8))
                add_char(noise_char(sep));
        end else begin
            parts = $urandom_range(1, 4);
            if ($urandom_range(5) == 0)
                add_char(sep);
            for (int p = 0; p < parts; p++) begin
                if (p != 0) begin
                    repeat ($urandom_range(1, 2))
                        add_char(sep);
                end
                case ($urandom_range(5))
                    0, 1, 2: begin
                        repeat ($urandom_range(1, 5))
                            add_char(word_char());
                    end
                    3, 4: begin
                        add_char(CH_QUOTE);
                        repeat ($urandom_range(0, 4)) begin
                            case ($urandom_range(5))
                                0: begin
                                    add_char(CH_BSLASH);
                                    add_char(esc_char());
                                end
                                1:       add_char(sep);
                                2:       add_char(CH_HASH);
                                default: add_char(word_char());
                            endcase
                        end
                        // closing quote most of the time, else a broken string
                        case ($urandom_range(7))
                            0: begin
                                add_char(CH_BSLASH);
                                add_char(8'($urandom_range(255)));
                            end
                            1:       add_char(CH_BSLASH);
                            2:       ;
                            default: add_char(CH_QUOTE);
                        endcase
                    end
                    default: begin
                        add_char(CH_HASH);
                        repeat ($urandom_range(0, 3))
                            add_char(noise_char(sep));
                    end
                endcase
            end
        end
    endtask

    // register write, only done while the block is idle
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and wait until every awaited result has come out
    task automatic wait_settled();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial begin : stimulus
        logic [7:0] split_now;
        logic       upper_now;
        int         goal;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed lines with reset settings: split on space, uppercase on
        // words, string with a valid escape, comment closing an open token
        load_text("ab \"q\\t\"#k");
        send_line();
        // unknown escape drops the rest of the line
        load_text("\"\\q");
        send_line();
        // backslash in a string as the last character
        load_text("\"\\");
        send_line();
        // unterminated string, hash and separator kept inside it
        load_text("\"# ");
        send_line();
        // line of just a separator, and a comment with no token open
        load_text(" ");
        send_line();
        load_text("#x");
        send_line();
        // extreme character codes
        add_char(8'h00);
        add_char(8'hFF);
        send_line();
        wait_settled();

        // random phases, each with its own register settings
        goal = items_sent;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin split_now = 8'h00;          upper_now = 1'b0; end
                1: begin split_now = 8'hFF;          upper_now = 1'b1; end
                2: begin split_now = CH_QUOTE;       upper_now = 1'b0; end
                3: begin split_now = CH_BSLASH;      upper_now = 1'b1; end
                4: begin split_now = SPLIT_CHAR_RST; upper_now = 1'b1; end
                5: begin split_now = CH_HASH;        upper_now = 1'b0; end
                default: begin
                    split_now = 8'($urandom_range(255));
                    upper_now = 1'($urandom_range(1));
                end
            endcase
            write_reg(CFG_SPLIT_CHAR, split_now);
            write_reg(CFG_UPPERCASE, {7'b0, upper_now});

            // sender idles lightly and receiver heavily, then swapped, then none
            send_idle = (ph < 2) ? 31 : (ph < 4) ? 70 : 0;
            recv_idle <= (ph < 2) ? 70 : (ph < 4) ? 31 : 0;

            // long output hold-off while lines keep coming, so the queue fills
            if (ph == 4)
                hold_kick <= hold_kick + 1;

            // one line, then the sender pauses until everything is out
            if (ph == 2) begin
                build_line(split_now);
                send_line();
                wait_settled();
            end

            goal += PHASE_ITEMS;
            while (items_sent < goal) begin
                build_line(split_now);
                send_line();
            end
            wait_settled();
        end

        if (fail_count == 0 && pending == 0)
            $display("quoted_line_tokenizer verification clean");
        else
            $display("quoted_line_tokenizer verification failed");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("quoted_line_tokenizer verification failed");
        $finish;
    end

endmodule
